@@ rtl/msst_pkg.sv @@
// Shared types, constants and width helpers for the moving sphere test.
`timescale 1ns / 1ps

package msst_pkg;

    localparam int COORD_BITS_DEF = 25;
    localparam int RAD_W          = 24;
    localparam int MIN_W          = 16;
    localparam int FRAC_BITS      = 16;
    localparam int TIME_W         = FRAC_BITS + 1;

    localparam logic [MIN_W-1:0]  MIN_MOTION_RESET = 16'd1;
    localparam logic [TIME_W-1:0] TIME_ONE         = 17'h10000;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_HIT     = 2'd2
    } status_t;

    // per-word control that rides alongside the datapath
    typedef struct packed {
        logic valid;
        logic overlap;
        logic reject;
    } msst_flags_t;

    // width of the Q.32 quadratic terms (cc, mm, mc, rr)
    function automatic int quad_width(input int cb);
        int a;
        int b;
        a = 2 * (cb + 1) + 2;
        b = 2 * (RAD_W + 1);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/moving_sphere_sphere_test_top.sv @@
// Top level: moving sphere versus moving sphere contact test, fully pipelined.
`timescale 1ns / 1ps
// Pipeline: front, discriminant, square root and divide stages, then the output
//   register; the square root takes one stage per root bit.
// Throughput: one word per cycle; the whole pipe advances together and holds
//   in place while the output word is not taken.
// Reset: rst_n async active low clears all valid bits; min_motion_sq -> 1.

module moving_sphere_sphere_test_top
    import msst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    // s_tdata, lowest bit up: center_dx, center_dy, center_dz, move_a_x,
    // move_a_y, move_a_z, move_b_x, move_b_y, move_b_z (COORD_BITS each),
    // radius_a, radius_b (24 each), zero pad to whole bytes
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [((9*COORD_BITS+2*RAD_W+7)/8)*8-1:0] s_tdata,

    // m_tdata, lowest bit up: hit_status (2), contact_time (17), zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((2+TIME_W+7)/8)*8-1:0]             m_tdata,

    // min_motion_sq write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MIN_W-1:0]    cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int QW    = quad_width(COORD_BITS);
    localparam int OUT_W = ((2 + TIME_W + 7) / 8) * 8;
    localparam int RA_LO = 9 * CB;
    localparam int RB_LO = 9 * CB + RAD_W;

    // config register
    logic [MIN_W-1:0] min_motion_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_motion_sq_reg <= MIN_MOTION_RESET;
        else if (cfg_valid)
            min_motion_sq_reg <= cfg_data;
    end

    // single advance strobe: every stage moves when the output slot frees
    logic en;
    logic out_valid;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid;

    // unpack input word
    logic [2:0][CB-1:0] center, move_a, move_b;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            center[k] = s_tdata[k*CB +: CB];
            move_a[k] = s_tdata[(3+k)*CB +: CB];
            move_b[k] = s_tdata[(6+k)*CB +: CB];
        end
    end

    // front: |c|, |m|, cc, mm, mc, rr and the cheap exits
    msst_flags_t   f_front, f_disc, f_sqrt;
    logic [QW-1:0] amc_f, mm_f, d_f;
    logic [QW-1:0] amc_d, mm_d;
    logic [QW-1:0] amc_s, mm_s, root_s;
    logic [2*QW-1:0] disc_d;

    msst_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .center        (center),
        .move_a        (move_a),
        .move_b        (move_b),
        .radius_a      (s_tdata[RA_LO +: RAD_W]),
        .radius_b      (s_tdata[RB_LO +: RAD_W]),
        .min_motion_sq (min_motion_sq_reg),
        .flags         (f_front),
        .amc           (amc_f),
        .mm            (mm_f),
        .cc_rr         (d_f)
    );

    // discriminant mc^2 - mm*(cc - rr), multiplies split into half words
    msst_disc #(.COORD_BITS(COORD_BITS)) u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_flags  (f_front),
        .amc       (amc_f),
        .mm        (mm_f),
        .cc_rr     (d_f),
        .out_flags (f_disc),
        .out_amc   (amc_d),
        .out_mm    (mm_d),
        .disc      (disc_d)
    );

    // floor(sqrt(disc)), one bit per stage
    msst_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_flags  (f_disc),
        .amc       (amc_d),
        .mm        (mm_d),
        .disc      (disc_d),
        .out_flags (f_sqrt),
        .out_amc   (amc_s),
        .out_mm    (mm_s),
        .root      (root_s)
    );

    // n = |mc| - s, hit if n <= mm, t = floor(n * 2^16 / mm)
    logic [1:0]        hit_status;
    logic [TIME_W-1:0] contact_time;

    msst_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_flags     (f_sqrt),
        .amc          (amc_s),
        .mm           (mm_s),
        .root         (root_s),
        .out_valid    (out_valid),
        .hit_status   (hit_status),
        .contact_time (contact_time)
    );

    assign m_tdata = OUT_W'({contact_time, hit_status});

endmodule

@@ rtl/msst_front.sv @@
// Front stages: magnitudes, products, dot-product sums and early-exit compares.
`timescale 1ns / 1ps

module msst_front
    import msst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][COORD_BITS-1:0]          center,
    input  logic [2:0][COORD_BITS-1:0]          move_a,
    input  logic [2:0][COORD_BITS-1:0]          move_b,
    input  logic [RAD_W-1:0]                    radius_a,
    input  logic [RAD_W-1:0]                    radius_b,
    input  logic [MIN_W-1:0]                    min_motion_sq,
    output msst_flags_t                         flags,
    output logic [quad_width(COORD_BITS)-1:0]   amc,
    output logic [quad_width(COORD_BITS)-1:0]   mm,
    output logic [quad_width(COORD_BITS)-1:0]   cc_rr
);

    localparam int CB = COORD_BITS;
    localparam int MB = COORD_BITS + 1;
    localparam int QW = quad_width(COORD_BITS);
    localparam int RS = RAD_W + 1;

    // stage 1: magnitudes
    logic [2:0][CB-1:0] ac_reg, ac_next;
    logic [2:0][MB-1:0] am_reg, am_next;
    logic [2:0]         sd_reg, sd_next;
    logic [RS-1:0]      rs_reg;
    logic               v1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [MB-1:0] m;
            logic signed [CB-1:0] c;
            c = $signed(center[k]);
            m = $signed({move_b[k][CB-1], move_b[k]}) - $signed({move_a[k][CB-1], move_a[k]});
            ac_next[k] = c[CB-1] ? CB'(-c) : CB'(c);
            am_next[k] = m[MB-1] ? MB'(-m) : MB'(m);
            sd_next[k] = c[CB-1] ^ m[MB-1];
        end
    end

    // stage 2: products
    logic [2:0][2*CB-1:0]    sqc_reg;
    logic [2:0][2*MB-1:0]    sqm_reg;
    logic [2:0][CB+MB-1:0]   p_reg;
    logic [2:0]              sd2_reg;
    logic [2*RS-1:0]         rr_reg;
    logic                    v2_reg;

    // stage 3: sums
    logic [QW-1:0] cc_reg, mm3_reg, mcp_reg, mcn_reg, rr3_reg;
    logic [QW-1:0] cc_next, mm3_next, mcp_next, mcn_next;
    logic          v3_reg;

    always_comb
    begin
        cc_next  = QW'(sqc_reg[0]) + QW'(sqc_reg[1]) + QW'(sqc_reg[2]);
        mm3_next = QW'(sqm_reg[0]) + QW'(sqm_reg[1]) + QW'(sqm_reg[2]);
        mcp_next = '0;
        mcn_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (sd2_reg[k])
                mcn_next = mcn_next + QW'(p_reg[k]);
            else
                mcp_next = mcp_next + QW'(p_reg[k]);
        end
    end

    // stage 4: early exits
    msst_flags_t   flags_reg, flags_next;
    logic [QW-1:0] amc_reg, mm_reg, d_reg;

    always_comb
    begin
        flags_next.valid   = v3_reg;
        flags_next.overlap = cc_reg < rr3_reg;
        flags_next.reject  = (mm3_reg < QW'(min_motion_sq)) || (mcp_reg >= mcn_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            flags_reg <= '0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg  <= ac_next;
            am_reg  <= am_next;
            sd_reg  <= sd_next;
            rs_reg  <= RS'(radius_a) + RS'(radius_b);
            for (int k = 0; k < 3; k++)
            begin
                sqc_reg[k] <= ac_reg[k] * ac_reg[k];
                sqm_reg[k] <= am_reg[k] * am_reg[k];
                p_reg[k]   <= (CB+MB)'(ac_reg[k]) * (CB+MB)'(am_reg[k]);
            end
            sd2_reg <= sd_reg;
            rr_reg  <= rs_reg * rs_reg;
            cc_reg  <= cc_next;
            mm3_reg <= mm3_next;
            mcp_reg <= mcp_next;
            mcn_reg <= mcn_next;
            rr3_reg <= QW'(rr_reg);
            amc_reg <= mcn_reg - mcp_reg;
            mm_reg  <= mm3_reg;
            d_reg   <= cc_reg - rr3_reg;
        end
    end

    assign flags = flags_reg;
    assign amc   = amc_reg;
    assign mm    = mm_reg;
    assign cc_rr = d_reg;

endmodule

@@ rtl/msst_disc.sv @@
// Discriminant stages: split wide products, partial-product sum, subtract.
`timescale 1ns / 1ps

module msst_disc
    import msst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  msst_flags_t                           in_flags,
    input  logic [quad_width(COORD_BITS)-1:0]     amc,
    input  logic [quad_width(COORD_BITS)-1:0]     mm,
    input  logic [quad_width(COORD_BITS)-1:0]     cc_rr,
    output msst_flags_t                           out_flags,
    output logic [quad_width(COORD_BITS)-1:0]     out_amc,
    output logic [quad_width(COORD_BITS)-1:0]     out_mm,
    output logic [2*quad_width(COORD_BITS)-1:0]   disc
);

    localparam int QW = quad_width(COORD_BITS);
    localparam int DW = 2 * QW;
    localparam int H  = (QW + 1) / 2;
    localparam int HH = QW - H;

    // stage 5: partial products
    logic [2*H-1:0]  aa_ll_reg, md_ll_reg;
    logic [H+HH-1:0] aa_lh_reg, md_lh_reg, md_hl_reg;
    logic [2*HH-1:0] aa_hh_reg, md_hh_reg;
    logic [QW-1:0]   amc5_reg, mm5_reg;
    msst_flags_t     f5_reg;

    // stage 6: sums
    logic [DW-1:0]   sq_reg, pr_reg;
    logic [QW-1:0]   amc6_reg, mm6_reg;
    msst_flags_t     f6_reg;

    // stage 7: difference
    logic [DW-1:0]   disc_reg;
    logic [QW-1:0]   amc7_reg, mm7_reg;
    msst_flags_t     f7_reg, f7_next;

    always_comb
    begin
        f7_next        = f6_reg;
        f7_next.reject = f6_reg.reject || (sq_reg < pr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f5_reg <= '0;
            f6_reg <= '0;
            f7_reg <= '0;
        end
        else if (en)
        begin
            f5_reg <= in_flags;
            f6_reg <= f5_reg;
            f7_reg <= f7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_ll_reg <= amc[H-1:0] * amc[H-1:0];
            aa_lh_reg <= (H+HH)'(amc[H-1:0]) * (H+HH)'(amc[QW-1:H]);
            aa_hh_reg <= amc[QW-1:H] * amc[QW-1:H];
            md_ll_reg <= mm[H-1:0] * cc_rr[H-1:0];
            md_lh_reg <= (H+HH)'(mm[H-1:0]) * (H+HH)'(cc_rr[QW-1:H]);
            md_hl_reg <= (H+HH)'(mm[QW-1:H]) * (H+HH)'(cc_rr[H-1:0]);
            md_hh_reg <= mm[QW-1:H] * cc_rr[QW-1:H];
            amc5_reg  <= amc;
            mm5_reg   <= mm;

            sq_reg    <= DW'(aa_ll_reg) + (DW'(aa_lh_reg) << (H + 1))
                         + (DW'(aa_hh_reg) << (2 * H));
            pr_reg    <= DW'(md_ll_reg) + ((DW'(md_lh_reg) + DW'(md_hl_reg)) << H)
                         + (DW'(md_hh_reg) << (2 * H));
            amc6_reg  <= amc5_reg;
            mm6_reg   <= mm5_reg;

            disc_reg  <= sq_reg - pr_reg;
            amc7_reg  <= amc6_reg;
            mm7_reg   <= mm6_reg;
        end
    end

    assign out_flags = f7_reg;
    assign out_amc   = amc7_reg;
    assign out_mm    = mm7_reg;
    assign disc      = disc_reg;

endmodule

@@ rtl/msst_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module msst_sqrt
    import msst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  msst_flags_t                           in_flags,
    input  logic [quad_width(COORD_BITS)-1:0]     amc,
    input  logic [quad_width(COORD_BITS)-1:0]     mm,
    input  logic [2*quad_width(COORD_BITS)-1:0]   disc,
    output msst_flags_t                           out_flags,
    output logic [quad_width(COORD_BITS)-1:0]     out_amc,
    output logic [quad_width(COORD_BITS)-1:0]     out_mm,
    output logic [quad_width(COORD_BITS)-1:0]     root
);

    localparam int QW = quad_width(COORD_BITS);
    localparam int DW = 2 * QW;
    localparam int SW = QW;

    logic [DW-1:0] rem_in   [SW];
    logic [SW-1:0] root_in  [SW];
    logic [QW-1:0] amc_in   [SW];
    logic [QW-1:0] mm_in    [SW];
    msst_flags_t   f_in     [SW];

    logic [DW-1:0] rem_reg  [SW];
    logic [SW-1:0] root_reg [SW];
    logic [QW-1:0] amc_reg  [SW];
    logic [QW-1:0] mm_reg   [SW];
    msst_flags_t   f_reg    [SW];

    for (genvar j = 0; j < SW; j++)
    begin : g_stage
        localparam int B = SW - 1 - j;
        logic [DW-1:0] trial;
        logic          take;

        if (j == 0)
        begin : g_first
            assign rem_in[j]  = disc;
            assign root_in[j] = '0;
            assign amc_in[j]  = amc;
            assign mm_in[j]   = mm;
            assign f_in[j]    = in_flags;
        end
        else
        begin : g_next
            assign rem_in[j]  = rem_reg[j-1];
            assign root_in[j] = root_reg[j-1];
            assign amc_in[j]  = amc_reg[j-1];
            assign mm_in[j]   = mm_reg[j-1];
            assign f_in[j]    = f_reg[j-1];
        end

        assign trial = (DW'(root_in[j]) << (B + 1)) | (DW'(1) << (2 * B));
        assign take  = rem_in[j] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                f_reg[j] <= '0;
            else if (en)
                f_reg[j] <= f_in[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= take ? (rem_in[j] - trial) : rem_in[j];
                root_reg[j] <= root_in[j] | (take ? (SW'(1) << B) : '0);
                amc_reg[j]  <= amc_in[j];
                mm_reg[j]   <= mm_in[j];
            end
        end
    end

    assign out_flags = f_reg[SW-1];
    assign out_amc   = amc_reg[SW-1];
    assign out_mm    = mm_reg[SW-1];
    assign root      = root_reg[SW-1];

endmodule

@@ rtl/msst_div.sv @@
// Contact check and pipelined fraction divide, ending in the output register.
`timescale 1ns / 1ps

module msst_div
    import msst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  msst_flags_t                         in_flags,
    input  logic [quad_width(COORD_BITS)-1:0]   amc,
    input  logic [quad_width(COORD_BITS)-1:0]   mm,
    input  logic [quad_width(COORD_BITS)-1:0]   root,
    output logic                                out_valid,
    output logic [1:0]                          hit_status,
    output logic [TIME_W-1:0]                   contact_time
);

    localparam int QW = quad_width(COORD_BITS);

    // check stage
    logic [QW-1:0]  n_next;
    logic           a_valid_reg, a_ovl_reg, a_hit_reg, a_eq_reg;
    logic [QW-1:0]  a_n_reg, a_mm_reg;

    assign n_next = amc - root;

    // divide stages
    logic [QW:0]           rm_in   [FRAC_BITS];
    logic [QW-1:0]         dm_in   [FRAC_BITS];
    logic [FRAC_BITS-1:0]  q_in    [FRAC_BITS];
    logic [2:0]            c_in    [FRAC_BITS];  // {eq, hit, overlap}
    logic                  v_in    [FRAC_BITS];

    logic [QW:0]           rm_reg  [FRAC_BITS];
    logic [QW-1:0]         dm_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0]  q_reg   [FRAC_BITS];
    logic [2:0]            c_reg   [FRAC_BITS];
    logic                  v_reg   [FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_ovl_reg   <= 1'b0;
            a_hit_reg   <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_flags.valid;
            a_ovl_reg   <= in_flags.overlap;
            a_hit_reg   <= !in_flags.overlap && !in_flags.reject && (n_next <= mm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_n_reg  <= n_next;
            a_mm_reg <= mm;
            a_eq_reg <= n_next == mm;
        end
    end

    for (genvar j = 0; j < FRAC_BITS; j++)
    begin : g_step
        logic [QW:0] sh;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign rm_in[j] = {1'b0, a_n_reg};
            assign dm_in[j] = a_mm_reg;
            assign q_in[j]  = '0;
            assign c_in[j]  = {a_eq_reg, a_hit_reg, a_ovl_reg};
            assign v_in[j]  = a_valid_reg;
        end
        else
        begin : g_next
            assign rm_in[j] = rm_reg[j-1];
            assign dm_in[j] = dm_reg[j-1];
            assign q_in[j]  = q_reg[j-1];
            assign c_in[j]  = c_reg[j-1];
            assign v_in[j]  = v_reg[j-1];
        end

        assign sh = {rm_in[j][QW-1:0], 1'b0};
        assign ge = sh >= {1'b0, dm_in[j]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
                c_reg[j] <= '0;
            end
            else if (en)
            begin
                v_reg[j] <= v_in[j];
                c_reg[j] <= c_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rm_reg[j] <= ge ? (sh - {1'b0, dm_in[j]}) : sh;
                dm_reg[j] <= dm_in[j];
                q_reg[j]  <= {q_in[j][FRAC_BITS-2:0], ge};
            end
        end
    end

    // output register
    status_t              st_next, st_reg;
    logic [TIME_W-1:0]    t_next, t_reg;
    logic                 ov_reg;
    logic [2:0]           cl;

    assign cl = c_reg[FRAC_BITS-1];

    always_comb
    begin
        if (cl[0])
            st_next = ST_OVERLAP;
        else if (cl[1])
            st_next = ST_HIT;
        else
            st_next = ST_NONE;

        if (!cl[0] && cl[1])
            t_next = cl[2] ? TIME_ONE : {1'b0, q_reg[FRAC_BITS-1]};
        else
            t_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v_reg[FRAC_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
            t_reg  <= t_next;
        end
    end

    assign out_valid    = ov_reg;
    assign hit_status   = st_reg;
    assign contact_time = t_reg;

endmodule
